### src/ffgs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the forest fire grid step unit.
// No dependencies; imported by every module of the block.

package ffgs_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int N_W        = $clog2(MAX_SIDE + 1);
  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int SCAN_LEN   = CELLS + MAX_SIDE;
  localparam int SCAN_W     = $clog2(SCAN_LEN + 1);
  localparam int SIDE_LEN_W = 7;
  localparam int POS_W      = 6;
  localparam int GEN_W      = 16;
  localparam int SIDE_RESET = 64;

  typedef logic [1:0] cell_t;

  localparam cell_t EMPTY   = 2'd0;
  localparam cell_t TREE    = 2'd1;
  localparam cell_t BURNING = 2'd2;
  localparam cell_t BURNT   = 2'd3;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_GEN   = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    cell_t            cell_value;
  } cmd_t;

  typedef struct packed {
    cell_t            read_value;
    logic             fire_still;
    logic [GEN_W-1:0] generations;
  } rsp_t;

  // Position of the cell under evaluation and the active side length.
  typedef struct packed {
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    logic [N_W-1:0]    side;
  } scan_pos_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GEN
  } state_t;

endpackage

### src/ffgs_window.sv
`timescale 1ns / 1ps
// Neighbourhood window for the generation scan: a two-row shift line plus the cell rule.
// Depends on ffgs_pkg.

module ffgs_window (
  input  logic                clk,
  input  logic                shift,
  input  ffgs_pkg::cell_t     din,
  input  ffgs_pkg::scan_pos_t pos,
  output ffgs_pkg::cell_t     nxt,
  output logic                ignite
);
  import ffgs_pkg::*;

  localparam int DEPTH = 2 * MAX_SIDE;
  localparam int X_W   = N_W + 1;

  cell_t          line [DEPTH];
  cell_t          up_c, down_c, left_c, right_c, mid_c;
  logic [X_W-1:0] row_x, col_x, side_x;
  logic           active, hot;

  // line[0] holds the cell read just before din; the centre sits one full row behind din.
  always_ff @(posedge clk) begin
    if (shift) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign down_c  = din;
  assign right_c = line[MAX_SIDE-2];
  assign mid_c   = line[MAX_SIDE-1];
  assign left_c  = line[MAX_SIDE];
  assign up_c    = line[DEPTH-1];

  always_comb begin
    row_x  = X_W'(pos.row);
    col_x  = X_W'(pos.col);
    side_x = X_W'(pos.side);
    active = (row_x < side_x) && (col_x < side_x);
    // The taps wrap across row ends, so each neighbour is masked by its own edge test.
    hot = ((row_x != '0) && (up_c == BURNING)) ||
          ((row_x + 1'b1 < side_x) && (down_c == BURNING)) ||
          ((col_x != '0) && (left_c == BURNING)) ||
          ((col_x + 1'b1 < side_x) && (right_c == BURNING));
    nxt    = mid_c;
    ignite = 1'b0;
    if (active) begin
      if (mid_c == BURNING) begin
        nxt = BURNT;
      end else if ((mid_c == TREE) && hot) begin
        nxt    = BURNING;
        ignite = 1'b1;
      end
    end
  end

endmodule

### src/forest_fire_grid_step_unit.sv
`timescale 1ns / 1ps
// Forest fire grid step unit. Cell write or undefined action: result registered in the cycle after
// acceptance. Cell read: the READ state, then the registered result. Generation: the result is
// registered with the last cell written, after one read of the current bank per cell scanned.
// One transaction at a time; the next can be taken in the same cycle as a pending result is taken.
// After reset a clearing pass writes every cell of both banks to empty, one address per
// cycle while no command is accepted; configuration writes are always taken.

module forest_fire_grid_step_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  ffgs_pkg::cmd_t                      cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output ffgs_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffgs_pkg::SIDE_LEN_W-1:0]     cfg_data
);
  import ffgs_pkg::*;

  state_t                state, state_next;
  logic [ADDR_W-1:0]     clr;
  logic [SCAN_W-1:0]     k;
  logic                  b_valid, b_inside, b_center;
  logic [SIDE_W-1:0]     cr, cc;
  logic [ADDR_W-1:0]     cidx;
  logic                  fire_acc;
  logic                  bank_sel;
  logic [GEN_W-1:0]      gen_count, gen_next;
  logic [SIDE_LEN_W-1:0] side_length;
  logic [N_W-1:0]        side_n;
  logic                  rd_ok;

  cell_t                 bank0 [CELLS];
  cell_t                 bank1 [CELLS];
  cell_t                 rdata0, rdata1, src_data, win_din, win_nxt, wdata;
  logic                  we0, we1;
  logic [ADDR_W-1:0]     waddr, raddr, cmd_addr;
  logic                  cmd_in_store, cmd_acc, center_we, last_center, win_ignite;
  scan_pos_t             win_pos;

  assign cfg_ready = 1'b1;

  assign cmd_addr     = ADDR_W'(32'(cmd.row) * MAX_SIDE + 32'(cmd.col));
  assign cmd_in_store = (32'(cmd.row) < MAX_SIDE) && (32'(cmd.col) < MAX_SIDE);
  assign cmd_stall    = !((state == ST_IDLE) && (!rsp_valid || !rsp_stall));
  assign cmd_acc      = cmd_valid && !cmd_stall;

  assign side_n   = (32'(side_length) > MAX_SIDE) ? N_W'(MAX_SIDE) : N_W'(side_length);
  assign gen_next = (gen_count == '1) ? gen_count : gen_count + 1'b1;

  assign src_data    = bank_sel ? rdata1 : rdata0;
  assign win_din     = b_inside ? src_data : EMPTY;
  assign center_we   = b_valid && b_center;
  assign last_center = center_we && (cidx == ADDR_W'(CELLS - 1));

  assign win_pos = '{row: cr, col: cc, side: side_n};

  ffgs_window u_window (
    .clk    (clk),
    .shift  (b_valid),
    .din    (win_din),
    .pos    (win_pos),
    .nxt    (win_nxt),
    .ignite (win_ignite)
  );

  // Grid banks: one write and one registered read per bank each cycle.
  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[waddr] <= wdata;
    end
    rdata0 <= bank0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      bank1[waddr] <= wdata;
    end
    rdata1 <= bank1[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we0        = 1'b0;
    we1        = 1'b0;
    waddr      = cmd_addr;
    wdata      = cmd.cell_value;
    raddr      = cmd_addr;
    unique case (state)
      ST_CLEAR: begin
        we0   = 1'b1;
        we1   = 1'b1;
        waddr = clr;
        wdata = EMPTY;
        if (clr == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_acc) begin
          unique case (cmd.action)
            ACT_WRITE: begin
              we0 = cmd_in_store && !bank_sel;
              we1 = cmd_in_store && bank_sel;
            end
            ACT_READ: state_next = ST_READ;
            ACT_GEN:  state_next = ST_GEN;
            default:  ;
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_GEN: begin
        // Reads run a row ahead of the writes; the two banks never share an access.
        raddr = k[ADDR_W-1:0];
        waddr = cidx;
        wdata = win_nxt;
        we0   = center_we && bank_sel;
        we1   = center_we && !bank_sel;
        if (last_center) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr         <= '0;
      b_valid     <= 1'b0;
      bank_sel    <= 1'b0;
      gen_count   <= '0;
      side_length <= SIDE_LEN_W'(SIDE_RESET);
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        side_length <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr <= clr + 1'b1;
      end
      b_valid <= (state == ST_GEN) && (k != SCAN_W'(SCAN_LEN));
      if ((cmd_acc && (cmd.action != ACT_READ) && (cmd.action != ACT_GEN)) ||
          (state == ST_READ) || last_center) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (last_center) begin
        bank_sel  <= ~bank_sel;
        gen_count <= gen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_inside <= k < SCAN_W'(CELLS);
    b_center <= k >= SCAN_W'(MAX_SIDE);
    if (cmd_acc) begin
      k        <= '0;
      cr       <= '0;
      cc       <= '0;
      cidx     <= '0;
      fire_acc <= 1'b0;
      rd_ok    <= cmd_in_store;
      rsp      <= '{read_value: EMPTY, fire_still: 1'b0, generations: gen_count};
    end
    if (state == ST_READ) begin
      rsp <= '{read_value: (rd_ok ? src_data : EMPTY), fire_still: 1'b0,
               generations: gen_count};
    end
    if (state == ST_GEN) begin
      if (k != SCAN_W'(SCAN_LEN)) begin
        k <= k + 1'b1;
      end
      if (center_we) begin
        cidx     <= cidx + 1'b1;
        fire_acc <= fire_acc | win_ignite;
        if (cc == SIDE_W'(MAX_SIDE - 1)) begin
          cc <= '0;
          cr <= cr + 1'b1;
        end else begin
          cc <= cc + 1'b1;
        end
      end
      if (last_center) begin
        rsp <= '{read_value: EMPTY, fire_still: (fire_acc | win_ignite),
                 generations: gen_next};
      end
    end
  end

endmodule

### src/ffgs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the forest fire grid step unit, bound to the top level.
// Depends on ffgs_pkg and forest_fire_grid_step_unit.

module ffgs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_stall,
  input ffgs_pkg::cmd_t                  cmd,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input ffgs_pkg::rsp_t                  rsp
);
  import ffgs_pkg::*;

  logic [1:0]       pending;
  logic [GEN_W-1:0] last_gen;
  logic             cmd_acc, rsp_acc;

  assign cmd_acc = cmd_valid && !cmd_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  // Transactions taken in but not yet answered, and the last count that was delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      last_gen <= '0;
    end else begin
      pending <= pending + 2'(cmd_acc) - 2'(rsp_acc);
      if (rsp_acc) begin
        last_gen <= rsp.generations;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or vanished");

  a_gen_monotonic: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.generations >= last_gen)
    else $error("generation count went backwards");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending == 2'd1)
    else $error("result without exactly one outstanding transaction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |-> (pending == 2'd0) || rsp_acc)
    else $error("command taken while a result is still owed");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> cmd_stall)
    else $error("command accepted during the clearing pass");

endmodule

bind forest_fire_grid_step_unit ffgs_checker u_ffgs_checker (.*);

### bench/ffgs_checker.sv
`timescale 1ns / 1ps
// Checker for the forest fire grid step unit: watches the command, result and
// configuration channels, predicts every result and compares it. Needs ffgs_pkg.

module ffgs_scoreboard
  import ffgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  cmd_t                  cmd,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [SIDE_LEN_W-1:0] cfg_data,
  input  logic                  final_sweep,
  output int unsigned           reports_due,
  output int unsigned           fault_count
);

  // Both banks of the grid; live selects the bank that reads and writes address.
  cell_t                 plane [0:1][0:CELLS-1];
  logic                  live;
  logic [GEN_W-1:0]      gen_total;
  logic [SIDE_LEN_W-1:0] side_reg;
  rsp_t                  due_reports [$];

  task automatic flag_fault(input string what);
    fault_count++;
    $display("[%0t] grid check: %s", $time, what);
  endtask

  // Applies one command to the grid copy and returns the result it must produce.
  function automatic rsp_t grid_outcome(input cmd_t item);
    rsp_t res;
    int   n;
    int   idx;
    int   r;
    int   c;
    logic hot;
    res = '0;
    idx = int'(item.row) * MAX_SIDE + int'(item.col);
    case (item.action)
      ACT_WRITE: begin
        if (item.row < MAX_SIDE && item.col < MAX_SIDE) plane[live][idx] = item.cell_value;
      end
      ACT_READ: begin
        if (item.row < MAX_SIDE && item.col < MAX_SIDE) res.read_value = plane[live][idx];
      end
      ACT_GEN: begin
        n = (int'(side_reg) > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
        for (int i = 0; i < CELLS; i++) plane[!live][i] = plane[live][i];
        for (r = 0; r < n; r++) begin
          for (c = 0; c < n; c++) begin
            idx = r * MAX_SIDE + c;
            if (plane[live][idx] == BURNING) begin
              plane[!live][idx] = BURNT;
            end else if (plane[live][idx] == TREE) begin
              hot = (r > 0 && plane[live][idx - MAX_SIDE] == BURNING) ||
                    (r + 1 < n && plane[live][idx + MAX_SIDE] == BURNING) ||
                    (c > 0 && plane[live][idx - 1] == BURNING) ||
                    (c + 1 < n && plane[live][idx + 1] == BURNING);
              if (hot) begin
                plane[!live][idx] = BURNING;
                res.fire_still = 1'b1;
              end
            end
          end
        end
        live = !live;
        if (gen_total != '1) gen_total++;
      end
      default: ;
    endcase
    res.generations = gen_total;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        plane[0][i] = EMPTY;
        plane[1][i] = EMPTY;
      end
      live = 1'b0;
      gen_total = '0;
      side_reg = SIDE_LEN_W'(SIDE_RESET);
      due_reports.delete();
      fault_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_reports.size() == 0) begin
          flag_fault($sformatf("result with nothing outstanding: read %0d fire %0d gen %0d",
                               rsp.read_value, rsp.fire_still, rsp.generations));
        end else begin
          want = due_reports.pop_front();
          if (rsp.read_value !== want.read_value)
            flag_fault($sformatf("read_value %0d, expected %0d",
                                 rsp.read_value, want.read_value));
          if (rsp.fire_still !== want.fire_still)
            flag_fault($sformatf("fire_still %0d, expected %0d",
                                 rsp.fire_still, want.fire_still));
          if (rsp.generations !== want.generations)
            flag_fault($sformatf("generations %0d, expected %0d",
                                 rsp.generations, want.generations));
        end
      end
      if (cmd_valid && !cmd_stall) due_reports.push_back(grid_outcome(cmd));
      if (cfg_valid && cfg_ready) side_reg = cfg_data;
      if (final_sweep && due_reports.size() != 0)
        flag_fault($sformatf("%0d results never arrived", due_reports.size()));
    end
    reports_due <= due_reports.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Top of the forest fire grid step unit bench: clock, reset, command and
// configuration stimulus and the verdict. Needs ffgs_pkg and ffgs_scoreboard.

module tb;
  import ffgs_pkg::*;

  localparam logic [1:0]  ACT_NOP     = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_t                  cmd = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SIDE_LEN_W-1:0] cfg_data = SIDE_LEN_W'(SIDE_RESET);
  logic                  final_sweep = 1'b0;
  logic                  calm = 1'b0;
  int unsigned           reports_due;
  int unsigned           fault_count;
  int unsigned           cycle_count = 0;
  int unsigned           items_sent = 0;
  int unsigned           gens_sent = 0;
  int unsigned           settings_seen = 0;
  int                    side_now = SIDE_RESET;

  forest_fire_grid_step_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ffgs_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .final_sweep (final_sweep),
    .reports_due (reports_due),
    .fault_count (fault_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("forest_fire_grid_step_unit test failed");
      $finish;
    end
  end

  // Trees dominate so that fires have something to spread through.
  function automatic cell_t pick_cell();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 55) return TREE;
    if (w < 75) return BURNING;
    if (w < 90) return EMPTY;
    return BURNT;
  endfunction

  task automatic issue(input logic [1:0] act, input int r, input int c, input cell_t v);
    cmd_t item;
    item.action     = act;
    item.row        = r[POS_W-1:0];
    item.col        = c[POS_W-1:0];
    item.cell_value = v;
    cmd_valid <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    items_sent++;
    if (act == ACT_GEN) gens_sent++;
    if (!calm && $urandom_range(99) < 9) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Holds off new commands until every outstanding result has been taken.
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_side(input int s);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= s[SIDE_LEN_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    side_now = s;
    settings_seen++;
  endtask

  // Mostly writes and reads inside a small patch of the active square, with
  // generations in between; the remainder touches the whole store or is a no-op.
  task automatic wild_phase(input int count);
    int span;
    int reach;
    int base_r;
    int base_c;
    int pick;
    span = (side_now == 0) ? 8 : ((side_now > MAX_SIDE) ? MAX_SIDE : side_now);
    reach = (span > 8) ? 8 : span;
    base_r = $urandom_range(span - reach);
    base_c = $urandom_range(span - reach);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        issue(ACT_WRITE, base_r + $urandom_range(reach - 1),
              base_c + $urandom_range(reach - 1), pick_cell());
      end else if (pick < 62) begin
        issue(ACT_READ, base_r + $urandom_range(reach - 1),
              base_c + $urandom_range(reach - 1), cell_t'($urandom_range(3)));
      end else if (pick < 85) begin
        issue(ACT_GEN, $urandom_range(63), $urandom_range(63), cell_t'($urandom_range(3)));
      end else if (pick < 93) begin
        issue($urandom_range(1) ? ACT_WRITE : ACT_READ, $urandom_range(63),
              $urandom_range(63), cell_t'($urandom_range(3)));
      end else begin
        issue(ACT_NOP, $urandom_range(63), $urandom_range(63), cell_t'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Full grid: corners, every cell value, an undefined action and a burn-out.
    issue(ACT_READ, 63, 63, EMPTY);
    issue(ACT_WRITE, 0, 0, TREE);
    issue(ACT_WRITE, 0, 1, BURNING);
    issue(ACT_WRITE, 63, 63, TREE);
    issue(ACT_WRITE, 62, 63, BURNING);
    issue(ACT_WRITE, 2, 2, BURNT);
    issue(ACT_WRITE, 2, 2, EMPTY);
    issue(ACT_NOP, 63, 63, BURNT);
    issue(ACT_GEN, 0, 0, EMPTY);
    issue(ACT_READ, 0, 0, EMPTY);
    issue(ACT_READ, 63, 63, EMPTY);
    issue(ACT_GEN, 63, 63, BURNT);
    issue(ACT_READ, 0, 1, EMPTY);

    // With no active cell a generation only copies the grid and counts.
    set_side(0);
    issue(ACT_WRITE, 5, 5, TREE);
    issue(ACT_WRITE, 5, 6, BURNING);
    issue(ACT_GEN, 0, 0, EMPTY);
    issue(ACT_READ, 5, 5, EMPTY);

    // A side length beyond the grid behaves as the full grid.
    set_side(127);
    issue(ACT_GEN, 0, 0, EMPTY);
    issue(ACT_READ, 5, 5, EMPTY);

    // A burning cell just outside the active square must not ignite its neighbour.
    set_side(2);
    issue(ACT_WRITE, 1, 1, TREE);
    issue(ACT_WRITE, 1, 2, BURNING);
    issue(ACT_GEN, 0, 0, EMPTY);
    issue(ACT_READ, 1, 1, EMPTY);

    set_side(1);
    issue(ACT_WRITE, 0, 0, TREE);
    issue(ACT_GEN, 0, 0, EMPTY);

    set_side(6);
    wild_phase(20);
    set_side(4);
    wild_phase(20);
    set_side(64);
    calm <= 1'b1;
    wild_phase(20);
    calm <= 1'b0;
    set_side($urandom_range(1, 10));
    wild_phase(20);
    set_side(2);
    wild_phase(17);
    set_side(127);
    wild_phase(17);

    settle();
    repeat (16) @(posedge clk);
    final_sweep <= 1'b1;
    @(posedge clk);
    final_sweep <= 1'b0;
    @(posedge clk);
    $display("Sent %0d grid commands, %0d of them generations, under %0d side lengths.",
             items_sent, gens_sent, settings_seen);
    $display("Side lengths ranged from zero and one through the full grid to out of range.");
    if (fault_count == 0) begin
      $display("forest_fire_grid_step_unit test passed");
    end else begin
      $display("forest_fire_grid_step_unit test failed");
    end
    $finish;
  end

endmodule
